[sv/sha256_pkg.sv]
`timescale 1ns / 1ps

package sha256_pkg;

   // Block geometry.
   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned WINDOW_WORDS = 16;
   localparam int unsigned HASH_WORDS = 8;
   localparam int unsigned LEN_POS = 56;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Source of the byte shifted into the message window.
   typedef enum logic [1:0] {
      BYTE_MSG  = 2'd0,
      BYTE_PAD  = 2'd1,
      BYTE_ZERO = 2'd2,
      BYTE_LEN  = 2'd3
   } byte_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         push;
      logic         count_inc;
      byte_sel_type byte_sel;
      logic [2:0]   len_idx;
      logic         vars_load;
      logic         round_step;
      logic [5:0]   round_idx;
      logic         hash_update;
      logic         out_load;
      logic         out_shift;
   } dp_cmd_type;

   typedef logic [31:0] word_type;

   function automatic word_type big_sig0(input word_type v);
      return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
   endfunction

   function automatic word_type big_sig1(input word_type v);
      return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
   endfunction

   function automatic word_type small_sig0(input word_type v);
      return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
   endfunction

   function automatic word_type small_sig1(input word_type v);
      return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'd0, v[31:10]};
   endfunction

   // Initial hash value for word i.
   function automatic word_type init_hash(input logic [2:0] i);
      word_type r;
      case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         3'd7: r = 32'h5be0cd19;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   // Round constant for round t.
   function automatic word_type round_const(input logic [5:0] t);
      word_type r;
      case (t)
         6'd0:  r = 32'h428a2f98;
         6'd1:  r = 32'h71374491;
         6'd2:  r = 32'hb5c0fbcf;
         6'd3:  r = 32'he9b5dba5;
         6'd4:  r = 32'h3956c25b;
         6'd5:  r = 32'h59f111f1;
         6'd6:  r = 32'h923f82a4;
         6'd7:  r = 32'hab1c5ed5;
         6'd8:  r = 32'hd807aa98;
         6'd9:  r = 32'h12835b01;
         6'd10: r = 32'h243185be;
         6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74;
         6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7;
         6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1;
         6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6;
         6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f;
         6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc;
         6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152;
         6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8;
         6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3;
         6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351;
         6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85;
         6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc;
         6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354;
         6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e;
         6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1;
         6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70;
         6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819;
         6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585;
         6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116;
         6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c;
         6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3;
         6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f;
         6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee;
         6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814;
         6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa;
         6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7;
         6'd63: r = 32'hc67178f2;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

[sv/sha256_stream_hasher_top.sv]
// SHA-256 stream hasher. Message bytes arrive one per transaction on the req
// channel; a transaction with tuser low carries no byte, and tlast marks the
// end of the message. Every 64th byte starts a compression (64 rounds on
// the one round unit, then the hash update) during which req_tready is low.
// After the last transaction the block pads to the end of the block and
// compresses; when fewer than eight bytes are left for the length, a second
// padded block follows. The S_FINAL state, left only once the previous
// digest has fully drained, moves the digest into the output buffer, after
// which the next message may start while the eight digest words, H0 first,
// drain on the rsp channel; tuser gives the word number and tlast marks
// word 7.
`timescale 1ns / 1ps

module sha256_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_number
   output logic        rsp_tlast    // last_word
);
   import sha256_pkg::*;

   dp_cmd_type cmd;

   sha256_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd)
   );

   sha256_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .msg_byte    (req_tdata),
      .digest_word (rsp_tdata)
   );

endmodule

[sv/sha256_ctrl.sv]
`timescale 1ns / 1ps

module sha256_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [2:0]             rsp_tuser,
   output logic                   rsp_tlast,
   output sha256_pkg::dp_cmd_type cmd
);
   import sha256_pkg::*;

   typedef enum logic [4:0] {
      S_LOAD   = 5'b00001,
      S_PAD    = 5'b00010,
      S_ROUND  = 5'b00100,
      S_UPDATE = 5'b01000,
      S_FINAL  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] pos_ff, pos_in;
   logic [5:0] round_ff, round_in;
   logic       pad_active_ff, pad_active_in;
   logic       pad_first_ff, pad_first_in;
   logic       len_ok_ff, len_ok_in;
   logic       final_ff, final_in;
   logic       out_busy_ff, out_busy_in;
   logic [2:0] out_cnt_ff, out_cnt_in;

   logic       req_fire;
   logic       rsp_fire;
   logic       block_full;
   logic [5:0] pos_after;

   assign req_tready = (state_ff == S_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = out_busy_ff;
   assign rsp_tuser  = out_cnt_ff;
   assign rsp_tlast  = (out_cnt_ff == 3'd7);

   // A present byte at the last block position fills the block.
   assign block_full = req_tuser && (pos_ff == 6'(BLOCK_BYTES - 1));
   assign pos_after  = pos_ff + {5'd0, req_tuser};

   // Next-state and command logic.
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      round_in      = round_ff;
      pad_active_in = pad_active_ff;
      pad_first_in  = pad_first_ff;
      len_ok_in     = len_ok_ff;
      final_in      = final_ff;
      out_busy_in   = out_busy_ff;
      out_cnt_in    = out_cnt_ff;

      cmd             = '0;
      cmd.byte_sel    = BYTE_MSG;
      cmd.len_idx     = pos_ff[2:0];
      cmd.round_idx   = round_ff;
      cmd.out_shift   = rsp_fire;

      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (req_tuser) begin
                  cmd.push      = 1'b1;
                  cmd.count_inc = 1'b1;
                  pos_in        = pos_ff + 6'd1;
               end
               if (block_full) begin
                  cmd.vars_load = 1'b1;
                  state_in      = S_ROUND;
                  if (req_tlast) begin
                     pad_active_in = 1'b1;
                     pad_first_in  = 1'b1;
                     len_ok_in     = 1'b1;
                  end
               end else if (req_tlast) begin
                  pad_active_in = 1'b1;
                  pad_first_in  = 1'b1;
                  len_ok_in     = (pos_after < 6'(LEN_POS));
                  state_in      = S_PAD;
               end
            end
         end
         S_PAD: begin
            cmd.push = 1'b1;
            if (pad_first_ff) begin
               cmd.byte_sel = BYTE_PAD;
            end else if (len_ok_ff && (pos_ff >= 6'(LEN_POS))) begin
               cmd.byte_sel = BYTE_LEN;
            end else begin
               cmd.byte_sel = BYTE_ZERO;
            end
            pad_first_in = 1'b0;
            pos_in       = pos_ff + 6'd1;
            if (pos_ff == 6'(BLOCK_BYTES - 1)) begin
               // Block complete: the length lands here unless it did not fit.
               cmd.vars_load = 1'b1;
               final_in      = len_ok_ff;
               len_ok_in     = 1'b1;
               state_in      = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round_step = 1'b1;
            round_in       = round_ff + 6'd1;
            if (round_ff == 6'(BLOCK_BYTES - 1)) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.hash_update = 1'b1;
            if (final_ff) begin
               state_in = S_FINAL;
            end else if (pad_active_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_FINAL: begin
            // Hand the digest to the output buffer once it has drained.
            if (!out_busy_ff) begin
               cmd.out_load  = 1'b1;
               pad_active_in = 1'b0;
               final_in      = 1'b0;
               state_in      = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // Output word counter.
      if (cmd.out_load) begin
         out_busy_in = 1'b1;
         out_cnt_in  = 3'd0;
      end else if (rsp_fire) begin
         out_cnt_in = out_cnt_ff + 3'd1;
         if (out_cnt_ff == 3'd7) begin
            out_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         pos_ff        <= '0;
         round_ff      <= '0;
         pad_active_ff <= 1'b0;
         pad_first_ff  <= 1'b0;
         len_ok_ff     <= 1'b0;
         final_ff      <= 1'b0;
         out_busy_ff   <= 1'b0;
         out_cnt_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         round_ff      <= round_in;
         pad_active_ff <= pad_active_in;
         pad_first_ff  <= pad_first_in;
         len_ok_ff     <= len_ok_in;
         final_ff      <= final_in;
         out_busy_ff   <= out_busy_in;
         out_cnt_ff    <= out_cnt_in;
      end
   end

endmodule

[sv/sha256_datapath.sv]
`timescale 1ns / 1ps

module sha256_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha256_pkg::dp_cmd_type cmd,
   input  logic [7:0]             msg_byte,
   output logic [31:0]            digest_word
);
   import sha256_pkg::*;

   word_type    window_ff [WINDOW_WORDS];
   word_type    hash_ff   [HASH_WORDS];
   word_type    vars_ff   [HASH_WORDS];
   word_type    out_ff    [HASH_WORDS];
   logic [63:0] count_ff;

   logic [7:0]  byte_in;
   logic [63:0] len_bits;
   logic [63:0] len_shift;
   word_type    sched_next;
   word_type    t1;
   word_type    t2;
   word_type    ch;
   word_type    maj;

   // Byte that enters the window on a push.
   assign len_bits  = {count_ff[60:0], 3'b000};
   assign len_shift = len_bits >> {~cmd.len_idx, 3'b000};

   always_comb begin
      case (cmd.byte_sel)
         BYTE_MSG:  byte_in = msg_byte;
         BYTE_PAD:  byte_in = PAD_BYTE;
         BYTE_ZERO: byte_in = 8'h00;
         BYTE_LEN:  byte_in = len_shift[7:0];
         default:   byte_in = 8'h00;
      endcase
   end

   // Message schedule: word 0 of the window is the current round's word.
   assign sched_next = small_sig1(window_ff[14]) + window_ff[9]
                     + small_sig0(window_ff[1]) + window_ff[0];

   // One compression round.
   assign ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign maj = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
              ^ (vars_ff[1] & vars_ff[2]);
   assign t1  = vars_ff[7] + big_sig1(vars_ff[4]) + ch
              + round_const(cmd.round_idx) + window_ff[0];
   assign t2  = big_sig0(vars_ff[0]) + maj;

   // The window shifts a byte in while loading or padding and a word while hashing.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
            window_ff[i] <= {window_ff[i][23:0], window_ff[i+1][31:24]};
         end
         window_ff[WINDOW_WORDS-1] <= {window_ff[WINDOW_WORDS-1][23:0], byte_in};
      end else if (cmd.round_step) begin
         for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
            window_ff[i] <= window_ff[i+1];
         end
         window_ff[WINDOW_WORDS-1] <= sched_next;
      end
   end

   // Working variables a through h.
   always_ff @(posedge clock) begin
      if (cmd.vars_load) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            vars_ff[i] <= hash_ff[i];
         end
      end else if (cmd.round_step) begin
         vars_ff[7] <= vars_ff[6];
         vars_ff[6] <= vars_ff[5];
         vars_ff[5] <= vars_ff[4];
         vars_ff[4] <= vars_ff[3] + t1;
         vars_ff[3] <= vars_ff[2];
         vars_ff[2] <= vars_ff[1];
         vars_ff[1] <= vars_ff[0];
         vars_ff[0] <= t1 + t2;
      end
   end

   // Running hash and message byte count.
   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            hash_ff[i] <= init_hash(3'(i));
         end
         count_ff <= '0;
      end else begin
         if (cmd.hash_update) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
               hash_ff[i] <= hash_ff[i] + vars_ff[i];
            end
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + 64'd1;
         end
      end
   end

   // Output buffer: takes the digest, then shifts one word per transaction.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            out_ff[i] <= hash_ff[i];
         end
      end else if (cmd.out_shift) begin
         for (int i = 0; i < HASH_WORDS - 1; i++) begin
            out_ff[i] <= out_ff[i+1];
         end
         out_ff[HASH_WORDS-1] <= out_ff[HASH_WORDS-1];
      end
   end

   assign digest_word = out_ff[0];

endmodule

[sv/sha256_checker.sv]
`timescale 1ns / 1ps

module sha256_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled digest word must hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("digest word changed while stalled");

   // The last flag goes with word seven and no other.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 3'd7)))
      else $error("last flag does not match word number");

   // Digest words come in order without gaps.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 3'd1))
      else $error("digest word sequence broken");

   // The end of a message is followed by padding, so input stalls.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken right after end of message");

endmodule

bind sha256_stream_hasher_top sha256_checker u_sha256_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
